>>> rtl/core/lcdw_pkg.sv
// shared types, codes and segment tables of the four-digit segment lcd writer
`default_nettype none

package lcdw_pkg;

    localparam int DIGIT_COUNT_DEF = 4;
    localparam int SHOWN_DIGITS    = 4;
    localparam int IN_WIDTH        = 24;
    localparam int OUT_WIDTH       = 72;
    localparam int REST_WIDTH      = 14;

    typedef enum logic [2:0] {
        ACT_PRINT   = 3'd0,
        ACT_HEX     = 3'd1,
        ACT_DEC     = 3'd2,
        ACT_DOT_SET = 3'd3,
        ACT_DOT_CLR = 3'd4,
        ACT_CLEAR   = 3'd5
    } t_action;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DIG_NIB   = 3'd1;
    localparam logic [2:0] STAT_NIB       = 3'd2;
    localparam logic [2:0] STAT_DIG       = 3'd3;
    localparam logic [2:0] STAT_DEC_RANGE = 3'd4;

    localparam logic [7:0]            DOT_MASK      = 8'h11;
    localparam logic [15:0]           DEC_LIMIT     = 16'd9999;
    localparam logic [REST_WIDTH-1:0] DEC_STEP_THOU = 14'd1000;
    localparam logic [REST_WIDTH-1:0] DEC_STEP_HUND = 14'd100;
    localparam logic [REST_WIDTH-1:0] DEC_STEP_TENS = 14'd10;

    typedef enum logic [1:0] {
        PLACE_THOU = 2'd0,
        PLACE_HUND = 2'd1,
        PLACE_TENS = 2'd2
    } t_place;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CHECK  = 2'd1,
        S_CONV   = 2'd2,
        S_COMMIT = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic dec_run;
        logic conv_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] seg_upper(input logic [3:0] nib);
        logic [7:0] seg;
        case (nib)
            4'h0: seg = 8'hEE;
            4'h1: seg = 8'h66;
            4'h2: seg = 8'hCC;
            4'h3: seg = 8'hEE;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'hAA;
            4'h6: seg = 8'hAA;
            4'h7: seg = 8'hEE;
            4'h8: seg = 8'hEE;
            4'h9: seg = 8'hEE;
            4'hA: seg = 8'hEE;
            4'hB: seg = 8'h22;
            4'hC: seg = 8'h88;
            4'hD: seg = 8'h66;
            4'hE: seg = 8'h88;
            default: seg = 8'h88;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] seg_lower(input logic [3:0] nib);
        logic [7:0] seg;
        case (nib)
            4'h0: seg = 8'hBB;
            4'h1: seg = 8'h00;
            4'h2: seg = 8'h77;
            4'h3: seg = 8'h55;
            4'h4: seg = 8'hCC;
            4'h5: seg = 8'hDD;
            4'h6: seg = 8'hFF;
            4'h7: seg = 8'h00;
            4'h8: seg = 8'hFF;
            4'h9: seg = 8'hDD;
            4'hA: seg = 8'hEE;
            4'hB: seg = 8'hFF;
            4'hC: seg = 8'hBB;
            4'hD: seg = 8'h77;
            4'hE: seg = 8'hFF;
            default: seg = 8'hEE;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcdw_ctrl.sv
// command sequencer of the segment lcd writer
`default_nettype none

module lcdw_ctrl
    import lcdw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.dec_run ? S_CONV : S_COMMIT;
            end
            S_CONV: begin
                if (i_status.conv_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lcdw_datapath.sv
// digit stores, decimal conversion and output register of the segment lcd writer
`default_nettype none

module lcdw_datapath
    import lcdw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [IN_WIDTH-1:0]  i_in_data,
    input  wire logic                 i_out_ready,
    output t_dp_status                o_status,
    output logic                      o_out_valid,
    output logic [OUT_WIDTH-1:0]      o_out_data
);

    localparam logic [3:0] DigitLimit = 4'(DIGIT_COUNT);

    t_action               r_action;
    logic [2:0]            r_digit;
    logic [15:0]           r_value;
    logic [REST_WIDTH-1:0] r_rest;
    logic [3:0]            r_thou;
    logic [3:0]            r_hund;
    logic [3:0]            r_tens;
    t_place                r_place;

    logic [7:0]            r_upper [DIGIT_COUNT];
    logic [7:0]            r_lower [DIGIT_COUNT];
    logic [7:0]            n_upper [DIGIT_COUNT];
    logic [7:0]            n_lower [DIGIT_COUNT];
    logic [2:0]            n_stat;

    logic                  r_out_valid;
    logic [OUT_WIDTH-1:0]  r_out_data;
    logic [OUT_WIDTH-1:0]  w_out_data;

    logic [REST_WIDTH-1:0] w_step;
    logic                  w_ge;
    logic                  w_dec_ok;
    logic                  w_digit_bad;
    logic                  w_nib_bad;
    logic [15:0]           w_dec_word;

    // subtraction step of the current decimal place
    always_comb begin
        case (r_place)
            PLACE_THOU: w_step = DEC_STEP_THOU;
            PLACE_HUND: w_step = DEC_STEP_HUND;
            PLACE_TENS: w_step = DEC_STEP_TENS;
            default:    w_step = DEC_STEP_TENS;
        endcase
    end

    assign w_ge        = (r_rest >= w_step);
    assign w_dec_ok    = (r_value <= DEC_LIMIT);
    assign w_digit_bad = ({1'b0, r_digit} >= DigitLimit);
    assign w_nib_bad   = |r_value[15:4];
    assign w_dec_word  = {r_thou, r_hund, r_tens, r_rest[3:0]};

    assign o_status.dec_run   = (r_action == ACT_DEC) && w_dec_ok;
    assign o_status.conv_done = (r_place == PLACE_TENS) && !w_ge;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_in_data[2:0]);
            r_digit  <= i_in_data[5:3];
            r_value  <= i_in_data[21:6];
            r_rest   <= i_in_data[6 +: REST_WIDTH];
            r_thou   <= '0;
            r_hund   <= '0;
            r_tens   <= '0;
            r_place  <= PLACE_THOU;
        end else if (i_cmd.conv) begin
            if (w_ge) begin
                r_rest <= r_rest - w_step;
                case (r_place)
                    PLACE_THOU: r_thou <= r_thou + 4'd1;
                    PLACE_HUND: r_hund <= r_hund + 4'd1;
                    default:    r_tens <= r_tens + 4'd1;
                endcase
            end else begin
                case (r_place)
                    PLACE_THOU: r_place <= PLACE_HUND;
                    default:    r_place <= PLACE_TENS;
                endcase
            end
        end
    end

    // store contents and status after the command
    always_comb begin
        logic [3:0] v_nib;
        v_nib  = '0;
        n_stat = STAT_OK;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            n_upper[i] = r_upper[i];
            n_lower[i] = r_lower[i];
        end
        case (r_action)
            ACT_PRINT: begin
                if (w_digit_bad && w_nib_bad) begin
                    n_stat = STAT_DIG_NIB;
                end else if (w_nib_bad) begin
                    n_stat = STAT_NIB;
                end else if (w_digit_bad) begin
                    n_stat = STAT_DIG;
                end else begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (r_digit == 3'(i)) begin
                            n_upper[i] = seg_upper(r_value[3:0]) | (r_upper[i] & DOT_MASK);
                            n_lower[i] = seg_lower(r_value[3:0]);
                        end
                    end
                end
            end
            ACT_HEX: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    v_nib      = 4'(32'(r_value) >> (4 * i));
                    n_upper[i] = seg_upper(v_nib) | (r_upper[i] & DOT_MASK);
                    n_lower[i] = seg_lower(v_nib);
                end
            end
            ACT_DEC: begin
                if (!w_dec_ok) begin
                    n_stat = STAT_DEC_RANGE;
                end else begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        v_nib      = 4'(32'(w_dec_word) >> (4 * i));
                        n_upper[i] = seg_upper(v_nib) | (r_upper[i] & DOT_MASK);
                        n_lower[i] = seg_lower(v_nib);
                    end
                end
            end
            ACT_DOT_SET: begin
                if (w_digit_bad) begin
                    n_stat = STAT_DIG;
                end else begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (r_digit == 3'(i)) n_upper[i] = r_upper[i] | DOT_MASK;
                    end
                end
            end
            ACT_DOT_CLR: begin
                if (w_digit_bad) begin
                    n_stat = STAT_DIG;
                end else begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (r_digit == 3'(i)) n_upper[i] = r_upper[i] & ~DOT_MASK;
                    end
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    n_upper[i] = '0;
                    n_lower[i] = '0;
                end
            end
            default: begin
                n_stat = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_upper[i] <= '0;
                r_lower[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_upper[i] <= n_upper[i];
                r_lower[i] <= n_lower[i];
            end
        end
    end

    // result packing, missing digits read as zero
    generate
        for (genvar g = 0; g < SHOWN_DIGITS; g++) begin : g_pack
            if (g < DIGIT_COUNT) begin : g_here
                assign w_out_data[8*g +: 8]                  = n_upper[g];
                assign w_out_data[8*(SHOWN_DIGITS+g) +: 8]   = n_lower[g];
            end else begin : g_absent
                assign w_out_data[8*g +: 8]                  = '0;
                assign w_out_data[8*(SHOWN_DIGITS+g) +: 8]   = '0;
            end
        end
    endgenerate
    assign w_out_data[8*2*SHOWN_DIGITS +: 3]             = n_stat;
    assign w_out_data[OUT_WIDTH-1 : 8*2*SHOWN_DIGITS+3]  = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/core/four_digit_segment_lcd_writer.sv
// top level of the four-digit segment lcd writer
`default_nettype none

// Keeps the upper (segments A/B/C plus dot bits 0x11) and lower (segments D/E/F/G)
// segment bytes of each digit and answers every command transfer with one result
// transfer holding all eight bytes and a status. The block works on one command at
// a time: every command passes from the idle state through the check state to the
// commit state, which waits until the output register is free; a decimal print of a
// value up to 9999 also passes through the conversion state, because the datapath
// finds each decimal digit by repeated subtraction, one subtraction per cycle, while
// the sequencer waits in that state. A finished result waits in the output
// register while the next command is taken in.

module four_digit_segment_lcd_writer
    import lcdw_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // action[2:0], digit[5:3], value[21:6], zero fill
    input  wire logic [IN_WIDTH-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // upper_byte_0..3[31:0], lower_byte_0..3[63:32], status[66:64], zero fill
    output logic [OUT_WIDTH-1:0]      m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lcdw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    lcdw_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
